@@ rtl/rad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_pkg: shared types and constants of the RTP audio depacketizer
// Item structs for both channels, header constants and block sizing.
// ----------------------------------------------------------------------------
package rad_pkg;

  // Block and packet sizing.
  localparam int BLOCK_BYTES      = 32;
  localparam int MAX_PACKET_BYTES = 1496;
  localparam int HEADER_BYTES     = 12;

  localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  // Header field values.
  localparam logic [1:0] RTP_VERSION = 2'd2;
  localparam logic [6:0] PT_ALAW     = 7'd8;
  localparam logic [6:0] PT_DYNAMIC  = 7'd96;

  // Byte offsets of the checked header fields.
  localparam logic [POS_W-1:0] POS_VER   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_PT    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SSRC0 = POS_W'(8);
  localparam logic [POS_W-1:0] POS_SSRC1 = POS_W'(9);
  localparam logic [POS_W-1:0] POS_SSRC2 = POS_W'(10);
  localparam logic [POS_W-1:0] POS_SSRC3 = POS_W'(11);

  // Queue between front and back end.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  audio_byte;
    logic [31:0] block_time;
    logic        block_end;
  } out_item_t;

  // Write side of the payload queue.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } q_push_t;

  // Read side of the payload queue.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } q_head_t;

  typedef enum logic {
    BK_FILL,
    BK_DRAIN
  } back_state_t;

endpackage

@@ rtl/rad_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_front: header checker and payload classifier
// Tracks the byte position, checks the fixed header and pushes payload bytes.
// ----------------------------------------------------------------------------
module rad_front import rad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  input  logic        q_full,
  output q_push_t     q_push
);

  logic [31:0]      ssrc_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hv_r, hv_nxt;
  logic             accept;
  logic             byte_ok;
  logic [7:0]       b;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.packet_byte;

  always_comb begin
    unique case (pos_r)
      POS_VER:   byte_ok = (b[7:6] == RTP_VERSION) && (b[3:0] == 4'd0);
      POS_PT:    byte_ok = (b[6:0] == PT_ALAW) || (b[6:0] == PT_DYNAMIC);
      POS_SSRC0: byte_ok = (b == ssrc_r[31:24]);
      POS_SSRC1: byte_ok = (b == ssrc_r[23:16]);
      POS_SSRC2: byte_ok = (b == ssrc_r[15:8]);
      POS_SSRC3: byte_ok = (b == ssrc_r[7:0]);
      default:   byte_ok = 1'b1;
    endcase
  end

  always_comb begin
    pos_nxt     = pos_r;
    hv_nxt      = hv_r;
    q_push.valid = 1'b0;
    q_push.data  = b;
    if (accept) begin
      if (pos_r < POS_W'(MAX_PACKET_BYTES)) begin
        if (pos_r < POS_W'(HEADER_BYTES)) begin
          if (!byte_ok) begin
            hv_nxt = 1'b0;
          end
        end else if (hv_r) begin
          q_push.valid = 1'b1;
        end
        pos_nxt = pos_r + POS_W'(1);
      end
      if (in_data.packet_end) begin
        pos_nxt = '0;
        hv_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssrc_r <= '0;
      pos_r  <= '0;
      hv_r   <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        ssrc_r <= cfg_wr_data;
      end
      pos_r <= pos_nxt;
      hv_r  <= hv_nxt;
    end
  end

endmodule

@@ rtl/rad_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_fifo: payload byte queue
// Short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module rad_fifo import rad_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  output logic    q_full,
  output q_head_t q_head,
  input  logic    q_pop
);

  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [7:0]         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign q_full      = (cnt_r == CNT_W'(Q_DEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.data  = mem_r[rd_ptr_r];
  assign do_push     = q_push.valid && !q_full;
  assign do_pop      = q_pop && q_head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/rad_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_back: block store and block drain
// Collects payload bytes into the block store and emits each full block.
// ----------------------------------------------------------------------------
module rad_back import rad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

  logic [7:0]       store_r [BLOCK_BYTES];
  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [31:0]      time_r, time_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic [31:0]      out_time_r;
  logic             out_end_r;
  logic             load;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    time_nxt      = time_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      BK_FILL: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          if (fill_r == LAST_IDX) begin
            fill_nxt   = '0;
            rd_idx_nxt = '0;
            state_nxt  = BK_DRAIN;
          end else begin
            fill_nxt = fill_r + IDX_W'(1);
          end
        end
      end
      BK_DRAIN: begin
        if (!out_valid_r || out_ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          if (rd_idx_r == LAST_IDX) begin
            time_nxt  = time_r + 32'(BLOCK_BYTES);
            state_nxt = BK_FILL;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = BK_FILL;
    endcase
  end

  // Block store and output register; the store read lands in the output register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      store_r[fill_r] <= q_head.data;
    end
    if (load) begin
      out_byte_r <= store_r[rd_idx_r];
      out_time_r <= time_r;
      out_end_r  <= (rd_idx_r == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FILL;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.audio_byte = out_byte_r;
  assign out_data.block_time = out_time_r;
  assign out_data.block_end  = out_end_r;

endmodule

@@ rtl/rtp_audio_depacketizer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_audio_depacketizer_unit: RTP A-law payload depacketizer
// Checks RTP headers byte by byte and emits payload in fixed-size blocks.
// ----------------------------------------------------------------------------
//
// Channel  Ports                           Carries
// -------  ------------------------------  -----------------------------------
// input    in_valid / in_ready / in_data   one packet byte and end mark (item)
// output   out_valid / out_ready / out_data one block byte, block time, end mark
// config   cfg_wr_en / cfg_wr_data         expected SSRC, written immediately
//
// Packet bytes are taken one per cycle while the payload queue has room.
// Each full block is read out of the block store at one item per cycle
// while the output is not stalled; during the drain the back end takes no
// new payload bytes, so intake stops once the queue (Q_DEPTH bytes) fills.
// Reset is synchronous and active low; it clears the SSRC register, the
// header tracker, the queue, the fill and drain counters and the block time.
// Output stalls only hold the output register and, through the queue, the input.
//
module rtp_audio_depacketizer_unit import rad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // Front end: byte position, header checks, and payload classification.
  rad_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push)
  );

  // Payload queue so that header work and block drains stall independently.
  rad_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // Back end: block store fill, drain, and running block time.
  rad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/rad_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_checker: port-level checks of the depacketizer
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module rad_checker import rad_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Inside a block the next item follows at once with the same block time.
  a_block_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.block_end |=>
      out_valid && $stable(out_data.block_time))
    else $error("block drain broke off or changed its block time");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rtp_audio_depacketizer_unit rad_checker u_rad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
